// ----- hw/rtl/mi3_pkg.sv -----
package mi3_pkg;

	localparam int DW   = 32;
	localparam int FB   = 16;
	localparam int NE   = 9;
	localparam int PW   = 2 * DW;
	localparam int CW   = 2 * DW + 1;
	localparam int DETW = DW + CW + 2;
	localparam int NW   = DETW + 2;
	localparam int QW   = DW + 1;
	localparam int RW   = NW + QW;

	typedef logic signed [DW-1:0]   ent_t;
	typedef logic signed [CW-1:0]   cof_t;
	typedef logic signed [DETW-1:0] det_t;

	localparam int unsigned CIX [NE][4] = '{
		'{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
		'{5, 6, 3, 8}, '{0, 8, 2, 6}, '{3, 2, 0, 5},
		'{3, 7, 4, 6}, '{6, 1, 0, 7}, '{0, 4, 3, 1}
	};

	typedef struct packed {
		logic                   sing;
		logic [NE-1:0]          neg;
		logic [NE-1:0]          ovf;
		logic [NE-1:0][RW-1:0]  rem;
		logic [NE-1:0][QW-1:0]  quo;
		logic [RW-1:0]          dsh;
	} div_t;

endpackage

// ----- hw/rtl/mi3_cof.sv -----
module mi3_cof (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_vld,
	input  mi3_pkg::ent_t [8:0]        m,
	output logic                       out_vld,
	output mi3_pkg::ent_t [8:0]        e,
	output mi3_pkg::cof_t [8:0]        c
);
	import mi3_pkg::*;

	logic                       vld_s1, vld_s2;
	ent_t [NE-1:0]              e_s1, e_s2;
	logic signed [PW-1:0]       pa_s1 [NE];
	logic signed [PW-1:0]       pb_s1 [NE];
	cof_t [NE-1:0]              c_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_s1 <= m;
			e_s2 <= e_s1;
			for (int i = 0; i < NE; i++) begin
				pa_s1[i] <= $signed(m[CIX[i][0]]) * $signed(m[CIX[i][1]]);
				pb_s1[i] <= $signed(m[CIX[i][2]]) * $signed(m[CIX[i][3]]);
				c_s2[i]  <= CW'(pa_s1[i]) - CW'(pb_s1[i]);
			end
		end
	end

	assign out_vld = vld_s2;
	assign e       = e_s2;
	assign c       = c_s2;
endmodule

// ----- hw/rtl/mi3_det.sv -----
module mi3_det (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_vld,
	input  mi3_pkg::ent_t [8:0]        e,
	input  mi3_pkg::cof_t [8:0]        c,
	output logic                       out_vld,
	output mi3_pkg::div_t              d
);
	import mi3_pkg::*;

	logic                     vld_s3, vld_s4, vld_s5;
	logic signed [PW:0]       pl_s3 [3];
	logic signed [PW:0]       ph_s3 [3];
	cof_t [NE-1:0]            c_s3, c_s4;
	det_t                     det_s4;
	det_t                     det_sum;
	div_t                     d_s5;
	div_t                     d_nxt;
	logic [DETW-1:0]          dmag;
	logic [CW-1:0]            cmag;
	logic [RW-1:0]            num;

	always_comb begin
		det_sum = '0;
		for (int j = 0; j < 3; j++) begin
			det_sum = det_sum + (DETW'(ph_s3[j]) <<< DW) + DETW'(pl_s3[j]);
		end
	end

	always_comb begin
		d_nxt      = '0;
		dmag       = det_s4[DETW-1] ? DETW'(-det_s4) : DETW'(det_s4);
		d_nxt.sing = (det_s4 == '0);
		d_nxt.dsh  = RW'(dmag) << QW;
		for (int i = 0; i < NE; i++) begin
			cmag          = c_s4[i][CW-1] ? CW'(-c_s4[i]) : CW'(c_s4[i]);
			num           = (RW'(cmag) << (2 * FB + 1)) + RW'(dmag);
			d_nxt.neg[i]  = c_s4[i][CW-1] ^ det_s4[DETW-1];
			d_nxt.ovf[i]  = (num >= (d_nxt.dsh << 1));
			d_nxt.rem[i]  = num;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s3 <= in_vld;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				pl_s3[j] <= $signed(e[j]) * $signed({1'b0, c[3*j][DW-1:0]});
				ph_s3[j] <= $signed(e[j]) * $signed(c[3*j][CW-1:DW]);
			end
			c_s3   <= c;
			c_s4   <= c_s3;
			det_s4 <= det_sum;
			d_s5   <= d_nxt;
		end
	end

	assign out_vld = vld_s5;
	assign d       = d_s5;
endmodule

// ----- hw/rtl/mi3_div_step.sv -----
module mi3_div_step (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  mi3_pkg::div_t     d_in,
	output logic              out_vld,
	output mi3_pkg::div_t     d_out
);
	import mi3_pkg::*;

	logic     vld_s1;
	div_t     d_s1;
	div_t     d_nxt;
	logic     ge;
	logic [RW-1:0] r1;

	always_comb begin
		d_nxt = d_in;
		for (int i = 0; i < NE; i++) begin
			ge            = (d_in.rem[i] >= d_in.dsh);
			r1            = ge ? d_in.rem[i] - d_in.dsh : d_in.rem[i];
			d_nxt.rem[i]  = r1 << 1;
			d_nxt.quo[i]  = {d_in.quo[i][QW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1 <= d_nxt;
		end
	end

	assign out_vld = vld_s1;
	assign d_out   = d_s1;
endmodule

// ----- hw/rtl/matrix3_inverse_unit.sv -----
// channel   signals                               direction
// in        in_valid, in_ready, m00..m22          item into the block
// out       out_valid, out_ready, r00..r22,       item out of the block
//           singular, saturated
//
// One item is accepted every cycle while the output is not stalled.
// The restoring divider resolves one quotient bit per stage.
// Reset clears every stage valid bit and the output valid bit.
// A stall at the output holds the whole pipeline; in_ready drops with it.
module matrix3_inverse_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  mi3_pkg::ent_t      m00,
	input  mi3_pkg::ent_t      m01,
	input  mi3_pkg::ent_t      m02,
	input  mi3_pkg::ent_t      m10,
	input  mi3_pkg::ent_t      m11,
	input  mi3_pkg::ent_t      m12,
	input  mi3_pkg::ent_t      m20,
	input  mi3_pkg::ent_t      m21,
	input  mi3_pkg::ent_t      m22,
	output logic               out_valid,
	input  logic               out_ready,
	output mi3_pkg::ent_t      r00,
	output mi3_pkg::ent_t      r01,
	output mi3_pkg::ent_t      r02,
	output mi3_pkg::ent_t      r10,
	output mi3_pkg::ent_t      r11,
	output mi3_pkg::ent_t      r12,
	output mi3_pkg::ent_t      r20,
	output mi3_pkg::ent_t      r21,
	output mi3_pkg::ent_t      r22,
	output logic               singular,
	output logic               saturated
);
	import mi3_pkg::*;

	localparam logic [QW-1:0] LIM_POS = QW'((64'd1 << (DW - 1)) - 64'd1);
	localparam logic [QW-1:0] LIM_NEG = QW'(64'd1 << (DW - 1));

	logic               en;
	ent_t [NE-1:0]      m;
	logic               cof_vld;
	ent_t [NE-1:0]      cof_e;
	cof_t [NE-1:0]      cof_c;
	logic               vchain [QW+1];
	div_t               dchain [QW+1];
	div_t               dl;
	ent_t [NE-1:0]      res_nxt;
	logic [NE-1:0]      sat_nxt;
	logic               vld_q;
	ent_t [NE-1:0]      res_q;
	logic               sing_q;
	logic               sat_q;

	assign en       = !vld_q || out_ready;
	assign in_ready = en;
	assign m = {m22, m21, m20, m12, m11, m10, m02, m01, m00};

	mi3_cof u_cof (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (in_valid),
		.m       (m),
		.out_vld (cof_vld),
		.e       (cof_e),
		.c       (cof_c)
	);

	mi3_det u_det (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (cof_vld),
		.e       (cof_e),
		.c       (cof_c),
		.out_vld (vchain[0]),
		.d       (dchain[0])
	);

	for (genvar k = 0; k < QW; k++) begin : g_div
		mi3_div_step u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.in_vld  (vchain[k]),
			.d_in    (dchain[k]),
			.out_vld (vchain[k+1]),
			.d_out   (dchain[k+1])
		);
	end

	assign dl = dchain[QW];

	always_comb begin
		for (int i = 0; i < NE; i++) begin
			sat_nxt[i] = !dl.sing && (dl.ovf[i] ||
				(dl.neg[i] ? (dl.quo[i] > LIM_NEG) : (dl.quo[i] > LIM_POS)));
			if (dl.sing) begin
				res_nxt[i] = '0;
			end else if (sat_nxt[i]) begin
				res_nxt[i] = dl.neg[i] ? ent_t'(LIM_NEG) : ent_t'(LIM_POS);
			end else begin
				res_nxt[i] = dl.neg[i] ? ent_t'(-dl.quo[i]) : ent_t'(dl.quo[i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vchain[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q  <= res_nxt;
			sing_q <= dl.sing;
			sat_q  <= |sat_nxt;
		end
	end

	assign out_valid = vld_q;
	assign singular  = sing_q;
	assign saturated = sat_q;
	assign r00 = res_q[0];
	assign r01 = res_q[1];
	assign r02 = res_q[2];
	assign r10 = res_q[3];
	assign r11 = res_q[4];
	assign r12 = res_q[5];
	assign r20 = res_q[6];
	assign r21 = res_q[7];
	assign r22 = res_q[8];

	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> !saturated && (res_q == '0))
		else $error("singular item with nonzero entries");

	a_sat_clip: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> (r00 == ent_t'(LIM_POS) || r00 == ent_t'(LIM_NEG) ||
			r01 == ent_t'(LIM_POS) || r01 == ent_t'(LIM_NEG) ||
			r02 == ent_t'(LIM_POS) || r02 == ent_t'(LIM_NEG) ||
			r10 == ent_t'(LIM_POS) || r10 == ent_t'(LIM_NEG) ||
			r11 == ent_t'(LIM_POS) || r11 == ent_t'(LIM_NEG) ||
			r12 == ent_t'(LIM_POS) || r12 == ent_t'(LIM_NEG) ||
			r20 == ent_t'(LIM_POS) || r20 == ent_t'(LIM_NEG) ||
			r21 == ent_t'(LIM_POS) || r21 == ent_t'(LIM_NEG) ||
			r22 == ent_t'(LIM_POS) || r22 == ent_t'(LIM_NEG)))
		else $error("saturated flag without a clipped entry");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en && vchain[QW] |=> vchain[QW] && $stable(dchain[QW]))
		else $error("divider tail changed during stall");
endmodule
